/* sv/rvb_pkg.sv */
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared types, tuning tables and fixed-point helpers of the stereo reverb.
// ----------------------------------------------------------------------------
`default_nettype none

package rvb_pkg;

   // Delay lengths at 44.1 kHz (left channel; right adds the stereo spread)
   localparam int COMB_LEN [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
   localparam int AP_LEN   [4] = '{556, 441, 341, 225};

   // Width of the clearing sweep address (largest comb memory fits)
   localparam int CLR_W = 14;

   // Lane micro-operations issued by the sequencer
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_START,
      OP_C_RD,
      OP_C_MULY,
      OP_C_MAC,
      OP_C_RND,
      OP_C_MULST,
      OP_C_WR,
      OP_SUM,
      OP_A_RD,
      OP_A_WR
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [2:0]       idx;
      logic [CLR_W-1:0] clr_addr;
   } lane_cmd_type;

   typedef struct packed {
      logic [15:0] input_gain;
      logic [15:0] wet_gain;
      logic [15:0] cross_gain;
      logic [15:0] dry_gain;
      logic [13:0] room_feedback;
      logic [14:0] damping;
   } cfg_type;

   // Start of comb line n in a channel's memory (n lines before it)
   function automatic int comb_base(input int n, input int sp);
      int s;
      s = 0;
      for (int j = 0; j < 8; j++) begin
         if (j < n) s = s + COMB_LEN[j] + sp;
      end
      return s;
   endfunction

   function automatic int ap_base(input int n, input int sp);
      int s;
      s = 0;
      for (int j = 0; j < 4; j++) begin
         if (j < n) s = s + AP_LEN[j] + sp;
      end
      return s;
   endfunction

   // Round a Q.14 product to nearest, halves toward plus infinity
   function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
      return (v + 64'sd8192) >>> 14;
   endfunction

   // Saturate to a signed sample of sb bits
   function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                 input int sb);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (sb - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      else if (v < lo) return lo;
      else return v;
   endfunction

endpackage

`default_nettype wire

/* sv/rvb_queue.sv */
// ----------------------------------------------------------------------------
// rvb_queue
// Front end: takes sample pairs and holds up to two for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rvb_queue #(
   parameter int W = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_pop,
   output logic [W-1:0] out_data
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic         pop;

   // Handshake and pointer advance
   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid & in_ready;
   assign pop       = out_pop & out_valid;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   // Fill level never passes the two slots
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && !push) |=> count_ff == 2'd0) else $error("queue underflow");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> count_ff == 2'd2) else $error("queue lost entry");

endmodule

`default_nettype wire

/* sv/rvb_lane.sv */
// ----------------------------------------------------------------------------
// rvb_lane
// One channel: comb and allpass delay memories, filter stores, positions and
// a multiply-accumulate unit, stepped by the sequencer's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rvb_lane #(
   parameter int NC     = 8,
   parameter int NA     = 4,
   parameter int SPREAD = 0,
   parameter int SB     = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rvb_pkg::lane_cmd_type  cmd,
   input  rvb_pkg::cfg_type       cfg,
   input  logic signed [SB-1:0]   x,
   output logic signed [SB-1:0]   ap_out
);

   localparam int CDEPTH = rvb_pkg::comb_base(NC, SPREAD);
   localparam int ADEPTH = rvb_pkg::ap_base(NA, SPREAD);
   localparam int CAW    = $clog2(CDEPTH);
   localparam int AAW    = $clog2(ADEPTH);
   localparam int PW     = SB + 18;
   localparam int ACW    = SB + 4;

   logic signed [SB-1:0] cmem [CDEPTH];
   logic signed [SB-1:0] amem [ADEPTH];

   logic [CAW-1:0] cbase [8];
   logic [10:0]    clen  [8];
   logic [AAW-1:0] abase [4];
   logic [9:0]     alen  [4];

   logic [10:0]          cpos_ff [8];
   logic [9:0]           apos_ff [4];
   logic signed [SB-1:0] st_ff   [8];

   logic signed [SB-1:0]  c_rd_ff, a_rd_ff;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff, acc_in;

   logic [1:0]           aidx;
   logic [CAW-1:0]       caddr, c_wa;
   logic [AAW-1:0]       aaddr, a_wa;
   logic                 c_we, a_we;
   logic signed [SB-1:0] c_wd, a_wd;
   logic [10:0]          cpos_in;
   logic [9:0]           apos_in;
   logic [14:0]          dm, dinv;
   logic signed [SB-1:0] ap_in;
   logic signed [63:0]   c_wval64, st_new64, a_wval64, ap_new64, sum_sat64, half64;

   // Constant line bases and lengths
   generate
      for (genvar g = 0; g < 8; g++) begin : g_comb
         assign cbase[g] = CAW'(rvb_pkg::comb_base(g, SPREAD));
         assign clen[g]  = 11'(rvb_pkg::COMB_LEN[g] + SPREAD);
      end
      for (genvar g = 0; g < 4; g++) begin : g_ap
         assign abase[g] = AAW'(rvb_pkg::ap_base(g, SPREAD));
         assign alen[g]  = 10'(rvb_pkg::AP_LEN[g] + SPREAD);
      end
   endgenerate

   // Addresses and damping terms
   assign aidx  = cmd.idx[1:0];
   assign caddr = cbase[cmd.idx] + CAW'(cpos_ff[cmd.idx]);
   assign aaddr = abase[aidx] + AAW'(apos_ff[aidx]);
   assign dm    = (cfg.damping > 15'd16384) ? 15'd16384 : cfg.damping;
   assign dinv  = 15'd16384 - dm;
   assign ap_in = $signed(acc_ff[SB-1:0]);
   assign ap_out = ap_in;

   // Sample arithmetic
   assign c_wval64  = rvb_pkg::sat_to(64'(x) + rvb_pkg::rnd14(64'(prod_ff)), SB);
   assign st_new64  = rvb_pkg::sat_to(rvb_pkg::rnd14(64'(prod_ff)), SB);
   assign half64    = (64'(a_rd_ff) + 64'sd1) >>> 1;
   assign a_wval64  = rvb_pkg::sat_to(64'(ap_in) + half64, SB);
   assign ap_new64  = rvb_pkg::sat_to(64'(a_rd_ff) - 64'(ap_in), SB);
   assign sum_sat64 = rvb_pkg::sat_to(64'(acc_ff), SB);

   assign cpos_in = (cpos_ff[cmd.idx] + 11'd1 == clen[cmd.idx]) ? 11'd0
                  : cpos_ff[cmd.idx] + 11'd1;
   assign apos_in = (apos_ff[aidx] + 10'd1 == alen[aidx]) ? 10'd0
                  : apos_ff[aidx] + 10'd1;

   // Memory write selection: clearing sweep or filter write-back
   always_comb begin
      c_we = 1'b0;
      c_wa = caddr;
      c_wd = c_wval64[SB-1:0];
      a_we = 1'b0;
      a_wa = aaddr;
      a_wd = a_wval64[SB-1:0];
      if (cmd.op == rvb_pkg::OP_CLEAR) begin
         c_wa = cmd.clr_addr[CAW-1:0];
         c_wd = '0;
         c_we = ({1'b0, cmd.clr_addr} < 15'(CDEPTH));
         a_wa = cmd.clr_addr[AAW-1:0];
         a_wd = '0;
         a_we = ({1'b0, cmd.clr_addr} < 15'(ADEPTH));
      end else if (cmd.op == rvb_pkg::OP_C_WR) begin
         c_we = 1'b1;
      end else if (cmd.op == rvb_pkg::OP_A_WR) begin
         a_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (c_we) cmem[c_wa] <= c_wd;
      c_rd_ff <= cmem[caddr];
   end

   always_ff @(posedge clock) begin
      if (a_we) amem[a_wa] <= a_wd;
      a_rd_ff <= amem[aaddr];
   end

   // Multiply-accumulate and channel sum
   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      unique case (cmd.op)
         rvb_pkg::OP_START:   acc_in = '0;
         rvb_pkg::OP_C_MULY: begin
            prod_in = PW'(c_rd_ff) * PW'($signed({1'b0, dinv}));
            acc_in  = acc_ff + ACW'(c_rd_ff);
         end
         rvb_pkg::OP_C_MAC:
            prod_in = prod_ff + PW'(st_ff[cmd.idx]) * PW'($signed({1'b0, dm}));
         rvb_pkg::OP_C_MULST:
            prod_in = PW'(st_ff[cmd.idx]) * PW'($signed({1'b0, cfg.room_feedback}));
         rvb_pkg::OP_SUM:     acc_in = ACW'(sum_sat64);
         rvb_pkg::OP_A_WR:    acc_in = ACW'(ap_new64);
         default: ;
      endcase
   end

   // Filter stores and positions
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            cpos_ff[i] <= '0;
            st_ff[i]   <= '0;
         end
         for (int i = 0; i < 4; i++) apos_ff[i] <= '0;
      end else begin
         if (cmd.op == rvb_pkg::OP_C_RND) st_ff[cmd.idx] <= st_new64[SB-1:0];
         if (cmd.op == rvb_pkg::OP_C_WR)  cpos_ff[cmd.idx] <= cpos_in;
         if (cmd.op == rvb_pkg::OP_A_WR)  apos_ff[aidx] <= apos_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Positions stay inside their lines
   a_cpos_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rvb_pkg::OP_C_WR |-> cpos_ff[cmd.idx] < clen[cmd.idx])
      else $error("comb position out of line");
   a_apos_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rvb_pkg::OP_A_WR |-> apos_ff[aidx] < alen[aidx])
      else $error("allpass position out of line");
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.op == rvb_pkg::OP_SUM) |-> acc_ff == ACW'(ap_in))
      else $error("comb sum not saturated");

endmodule

`default_nettype wire

/* sv/rvb_engine.sv */
// ----------------------------------------------------------------------------
// rvb_engine
// Back end: sequencer over both lanes, input scaling, output mix and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rvb_engine #(
   parameter int NC     = 8,
   parameter int NA     = 4,
   parameter int SPREAD = 23,
   parameter int SB     = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rvb_pkg::cfg_type      cfg,
   input  logic                  q_valid,
   input  logic signed [SB-1:0]  q_left,
   input  logic signed [SB-1:0]  q_right,
   output logic                  q_pop,
   output logic                  clearing,
   output rvb_pkg::lane_cmd_type cmd,
   output logic signed [SB-1:0]  x,
   input  logic signed [SB-1:0]  ap_left,
   input  logic signed [SB-1:0]  ap_right,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [SB-1:0]  rsp_left_out,
   output logic signed [SB-1:0]  rsp_right_out
);

   localparam int XW = SB + 19;
   localparam int MW = SB + 20;
   // Sweep the larger of the comb and allpass memories
   localparam int CLR_COMB = rvb_pkg::comb_base(NC, SPREAD);
   localparam int CLR_AP   = rvb_pkg::ap_base(NA, SPREAD);
   localparam int CLR_N    = (CLR_COMB > CLR_AP) ? CLR_COMB : CLR_AP;
   localparam logic [rvb_pkg::CLR_W-1:0] CLR_LAST = rvb_pkg::CLR_W'(CLR_N - 1);
   localparam logic [2:0] LAST_C = 3'(NC - 1);
   localparam logic [2:0] LAST_A = 3'(NA - 1);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_X_MUL, ST_X_RND,
      ST_C_RD, ST_C_MULY, ST_C_MAC, ST_C_RND, ST_C_MULST, ST_C_WR,
      ST_SUM, ST_A_RD, ST_A_WR,
      ST_M_WET, ST_M_CROSS, ST_M_DRY, ST_M_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 idx_ff, idx_in;
   logic [rvb_pkg::CLR_W-1:0]  clr_ff, clr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]       l_ff, l_in, r_ff, r_in;
   logic signed [XW-1:0]       xp_ff, xp_in;
   logic signed [SB-1:0]       x_ff, x_in;
   logic signed [MW-1:0]       ml_ff, ml_in, mr_ff, mr_in;
   logic signed [SB-1:0]       ol_ff, ol_in, or_ff, or_in;
   logic signed [SB:0]         lr_sum;
   logic signed [63:0]         x64, ol64, or64;
   logic                       load;

   assign lr_sum = (SB+1)'(l_ff) + (SB+1)'(r_ff);
   assign x64  = rvb_pkg::sat_to(rvb_pkg::rnd14(64'(xp_ff)), SB);
   assign ol64 = rvb_pkg::sat_to(rvb_pkg::rnd14(64'(ml_ff)), SB);
   assign or64 = rvb_pkg::sat_to(rvb_pkg::rnd14(64'(mr_ff)), SB);

   assign clearing      = (state_ff == ST_CLEAR);
   assign x             = x_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = ol_ff;
   assign rsp_right_out = or_ff;

   // Sequencer: next state, lane command and datapath next values
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      xp_in        = xp_ff;
      x_in         = x_ff;
      ml_in        = ml_ff;
      mr_in        = mr_ff;
      ol_in        = ol_ff;
      or_in        = or_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      cmd.op       = rvb_pkg::OP_NONE;
      cmd.idx      = idx_ff;
      cmd.clr_addr = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = rvb_pkg::OP_CLEAR;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               l_in     = q_left;
               r_in     = q_right;
               state_in = ST_X_MUL;
            end
         end
         ST_X_MUL: begin
            xp_in    = XW'(lr_sum) * XW'($signed({1'b0, cfg.input_gain}));
            state_in = ST_X_RND;
         end
         ST_X_RND: begin
            x_in     = x64[SB-1:0];
            cmd.op   = rvb_pkg::OP_START;
            idx_in   = '0;
            state_in = ST_C_RD;
         end
         ST_C_RD: begin
            cmd.op   = rvb_pkg::OP_C_RD;
            state_in = ST_C_MULY;
         end
         ST_C_MULY: begin
            cmd.op   = rvb_pkg::OP_C_MULY;
            state_in = ST_C_MAC;
         end
         ST_C_MAC: begin
            cmd.op   = rvb_pkg::OP_C_MAC;
            state_in = ST_C_RND;
         end
         ST_C_RND: begin
            cmd.op   = rvb_pkg::OP_C_RND;
            state_in = ST_C_MULST;
         end
         ST_C_MULST: begin
            cmd.op   = rvb_pkg::OP_C_MULST;
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            cmd.op = rvb_pkg::OP_C_WR;
            if (idx_ff == LAST_C) begin
               idx_in   = '0;
               state_in = ST_SUM;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_C_RD;
            end
         end
         ST_SUM: begin
            cmd.op   = rvb_pkg::OP_SUM;
            state_in = ST_A_RD;
         end
         ST_A_RD: begin
            cmd.op   = rvb_pkg::OP_A_RD;
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            cmd.op = rvb_pkg::OP_A_WR;
            if (idx_ff == LAST_A) begin
               idx_in   = '0;
               state_in = ST_M_WET;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_A_RD;
            end
         end
         ST_M_WET: begin
            ml_in    = MW'(ap_left) * MW'($signed({1'b0, cfg.wet_gain}));
            mr_in    = MW'(ap_right) * MW'($signed({1'b0, cfg.wet_gain}));
            state_in = ST_M_CROSS;
         end
         ST_M_CROSS: begin
            ml_in    = ml_ff + MW'(ap_right) * MW'($signed({1'b0, cfg.cross_gain}));
            mr_in    = mr_ff + MW'(ap_left) * MW'($signed({1'b0, cfg.cross_gain}));
            state_in = ST_M_DRY;
         end
         ST_M_DRY: begin
            ml_in    = ml_ff + MW'(l_ff) * MW'($signed({1'b0, cfg.dry_gain}));
            mr_in    = mr_ff + MW'(r_ff) * MW'($signed({1'b0, cfg.dry_gain}));
            state_in = ST_M_OUT;
         end
         ST_M_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               ol_in    = ol64[SB-1:0];
               or_in    = or64[SB-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      l_ff  <= l_in;
      r_ff  <= r_in;
      xp_ff <= xp_in;
      x_ff  <= x_in;
      ml_ff <= ml_in;
      mr_ff <= mr_in;
      ol_ff <= ol_in;
      or_ff <= or_in;
   end

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop) else $error("item taken during clearing pass");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(ol_ff) && $stable(or_ff))
      else $error("pending result overwritten");
   a_comb_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_C_WR |-> idx_ff <= LAST_C) else $error("comb index out of range");
   a_ap_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_A_WR |-> idx_ff <= LAST_A) else $error("allpass index out of range");

endmodule

`default_nettype wire

/* sv/stereo_comb_allpass_reverb_top.sv */
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_top
// Stereo comb/allpass reverb: input queue, sequenced back end with one
// lane per channel, and the register port.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_left_sample, req_right_sample
//   rsp_      out        rsp_valid/rsp_ready    rsp_left_out, rsp_right_out
//   register  in/out     psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// Most of the work on a sample pair lies in the comb loop: six steps of the
// per-channel multiply-accumulate unit for each comb filter. The back end
// takes the next pair from the queue only once it is through with the last.
// After reset a clearing pass over the addresses of the larger delay memory
// zeroes the delay memories; req_ready stays low meanwhile.
// The queue holds two pairs, and one result waits in the output register
// while the next pair is worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_comb_allpass_reverb_top #(
   parameter int NUM_COMB_FILTERS    = 8,
   parameter int NUM_ALLPASS_FILTERS = 4,
   parameter int STEREO_SPREAD       = 23,
   parameter int SAMPLE_BITS         = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int NC = (NUM_COMB_FILTERS < 1) ? 1 :
                       ((NUM_COMB_FILTERS > 8) ? 8 : NUM_COMB_FILTERS);
   localparam int NA = (NUM_ALLPASS_FILTERS < 1) ? 1 :
                       ((NUM_ALLPASS_FILTERS > 4) ? 4 : NUM_ALLPASS_FILTERS);
   localparam int SPREAD = (STEREO_SPREAD < 0) ? 0 :
                           ((STEREO_SPREAD > 64) ? 64 : STEREO_SPREAD);
   localparam int SB = SAMPLE_BITS;

   localparam logic [2:0] REG_INPUT_GAIN = 3'd0;
   localparam logic [2:0] REG_WET_GAIN   = 3'd1;
   localparam logic [2:0] REG_CROSS_GAIN = 3'd2;
   localparam logic [2:0] REG_DRY_GAIN   = 3'd3;
   localparam logic [2:0] REG_ROOM       = 3'd4;
   localparam logic [2:0] REG_DAMPING    = 3'd5;

   rvb_pkg::cfg_type      cfg_ff, cfg_in;
   rvb_pkg::lane_cmd_type cmd;
   logic                  wr_en;
   logic [2:0]            reg_idx;
   logic                  q_ready, q_valid, q_pop, clearing;
   logic [2*SB-1:0]       q_data;
   logic signed [SB-1:0]  x, ap_left, ap_right;

   // Register port
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_INPUT_GAIN: cfg_in.input_gain    = pwdata[15:0];
            REG_WET_GAIN:   cfg_in.wet_gain      = pwdata[15:0];
            REG_CROSS_GAIN: cfg_in.cross_gain    = pwdata[15:0];
            REG_DRY_GAIN:   cfg_in.dry_gain      = pwdata[15:0];
            REG_ROOM:       cfg_in.room_feedback = pwdata[13:0];
            REG_DAMPING:    cfg_in.damping       = pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INPUT_GAIN: prdata = {16'd0, cfg_ff.input_gain};
         REG_WET_GAIN:   prdata = {16'd0, cfg_ff.wet_gain};
         REG_CROSS_GAIN: prdata = {16'd0, cfg_ff.cross_gain};
         REG_DRY_GAIN:   prdata = {16'd0, cfg_ff.dry_gain};
         REG_ROOM:       prdata = {18'd0, cfg_ff.room_feedback};
         REG_DAMPING:    prdata = {17'd0, cfg_ff.damping};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_gain    <= 16'd246;
         cfg_ff.wet_gain      <= 16'd16384;
         cfg_ff.cross_gain    <= 16'd0;
         cfg_ff.dry_gain      <= 16'd0;
         cfg_ff.room_feedback <= 14'd13762;
         cfg_ff.damping       <= 15'd3277;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end; no transfer during the clearing pass
   assign req_ready = q_ready & ~clearing;

   rvb_queue #(.W(2*SB)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid & ~clearing),
      .in_ready  (q_ready),
      .in_data   ({req_left_sample, req_right_sample}),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_data)
   );

   rvb_engine #(.NC(NC), .NA(NA), .SPREAD(SPREAD), .SB(SB)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_valid),
      .q_left        ($signed(q_data[2*SB-1:SB])),
      .q_right       ($signed(q_data[SB-1:0])),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .cmd           (cmd),
      .x             (x),
      .ap_left       (ap_left),
      .ap_right      (ap_right),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   rvb_lane #(.NC(NC), .NA(NA), .SPREAD(0), .SB(SB)) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .cfg    (cfg_ff),
      .x      (x),
      .ap_out (ap_left)
   );

   rvb_lane #(.NC(NC), .NA(NA), .SPREAD(SPREAD), .SB(SB)) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .cfg    (cfg_ff),
      .x      (x),
      .ap_out (ap_right)
   );

endmodule

`default_nettype wire
